// ===== design/slotalloc_pkg.sv =====
package slotalloc_pkg;

  localparam int MaxSlots = 64;
  localparam int SlotW    = $clog2(MaxSlots);
  localparam int CntW     = $clog2(MaxSlots + 1);
  localparam int CapW     = 7;
  localparam int CmdW     = 2;
  localparam int IdW      = 32;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 7;

  typedef enum logic [CmdW-1:0] {
    CmdAlloc   = 2'd0,
    CmdRelease = 2'd1,
    CmdClear   = 2'd2
  } cmd_t;

  localparam logic [CfgIdxW-1:0] CfgCapacity = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgReplace  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } dp_status_t;

  typedef struct packed {
    logic             success;
    logic [SlotW-1:0] granted_slot;
    logic [IdW-1:0]   granted_id;
    logic             evicted;
    logic [IdW-1:0]   evicted_id;
    logic [CntW-1:0]  active_count;
  } res_t;

endpackage

// ===== design/slotalloc_if.sv =====
interface slotalloc_in_if;
  logic                           valid;
  logic                           ready;
  logic [slotalloc_pkg::CmdW-1:0]  command;
  logic [slotalloc_pkg::SlotW-1:0] slot;

  modport source(output valid, command, slot, input ready);
  modport sink(input valid, command, slot, output ready);
endinterface

interface slotalloc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           success;
  logic [slotalloc_pkg::SlotW-1:0] granted_slot;
  logic [slotalloc_pkg::IdW-1:0]   granted_id;
  logic                           evicted;
  logic [slotalloc_pkg::IdW-1:0]   evicted_id;
  logic [slotalloc_pkg::CntW-1:0]  active_count;

  modport source(output valid, success, granted_slot, granted_id, evicted, evicted_id,
                 active_count, input ready);
  modport sink(input valid, success, granted_slot, granted_id, evicted, evicted_id,
               active_count, output ready);
endinterface

interface slotalloc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [slotalloc_pkg::CfgIdxW-1:0]  index;
  logic [slotalloc_pkg::CfgDataW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/slotalloc_ctrl.sv =====
module slotalloc_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [slotalloc_pkg::CmdW-1:0] in_command,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output slotalloc_pkg::ctrl_cmd_t       cmd,
  input  slotalloc_pkg::dp_status_t      status
);
  import slotalloc_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StScan   = 4'b0010,
    StDrain  = 4'b0100,
    StCommit = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == StIdle);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      StIdle: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = (in_command == CmdAlloc) ? StScan : StCommit;
        end
      end
      StScan: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_nxt = StDrain;
        end
      end
      // last read of the scan still in flight
      StDrain: begin
        state_nxt = StCommit;
      end
      StCommit: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/slotalloc_dp.sv =====
module slotalloc_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  slotalloc_pkg::ctrl_cmd_t           cmd,
  output slotalloc_pkg::dp_status_t          status,
  input  logic [slotalloc_pkg::CmdW-1:0]     in_command,
  input  logic [slotalloc_pkg::SlotW-1:0]    in_slot,
  input  logic                               cfg_we,
  input  logic [slotalloc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [slotalloc_pkg::CfgDataW-1:0] cfg_data,
  output slotalloc_pkg::res_t                result
);
  import slotalloc_pkg::*;

  // configuration
  logic [CapW-1:0] cap_r;
  logic            replace_r;
  logic [CntW-1:0] cap_eff;

  // slot table
  logic [MaxSlots-1:0] active_r, active_nxt;
  logic [IdW-1:0]      id_mem [MaxSlots];
  logic [IdW-1:0]      next_id_r, next_id_nxt, next_id_inc;
  logic [CntW-1:0]     live_r, live_nxt;

  // latched command
  cmd_t             cmd_r;
  logic [SlotW-1:0] slot_r;

  // scan pipeline
  logic [SlotW-1:0] addr_r;
  logic             rd_vld_r;
  logic             rd_act_r;
  logic [SlotW-1:0] rd_idx_r;
  logic [IdW-1:0]   rd_id_r;

  // scan trackers
  logic             free_found_r;
  logic [SlotW-1:0] free_idx_r;
  logic             best_vld_r;
  logic [SlotW-1:0] best_idx_r;
  logic [IdW-1:0]   best_id_r;

  // commit
  logic             mem_we;
  logic [SlotW-1:0] wr_slot;
  res_t             res_nxt;
  res_t             result_r;

  always_comb begin
    if (cap_r == CapW'(0)) begin
      cap_eff = CntW'(1);
    end else if (CntW'(cap_r) > CntW'(MaxSlots)) begin
      cap_eff = CntW'(MaxSlots);
    end else begin
      cap_eff = CntW'(cap_r);
    end
  end

  assign status.scan_last = ({1'b0, addr_r} == (cap_eff - CntW'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CapW'(MaxSlots);
      replace_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgCapacity: cap_r     <= cfg_data[CapW-1:0];
        CfgReplace:  replace_r <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // id store: one write port at commit, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[wr_slot] <= next_id_r;
    end
    rd_id_r <= id_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= cmd_t'(in_command);
      slot_r <= in_slot;
    end
    rd_act_r <= active_r[addr_r];
    rd_idx_r <= addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.load) begin
        addr_r <= '0;
      end else if (cmd.scan) begin
        addr_r <= addr_r + SlotW'(1);
      end
    end
  end

  // first free slot and active slot with the smallest id, lowest index on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_found_r <= 1'b0;
      best_vld_r   <= 1'b0;
    end else if (cmd.load) begin
      free_found_r <= 1'b0;
      best_vld_r   <= 1'b0;
    end else if (rd_vld_r) begin
      if (!rd_act_r && !free_found_r) begin
        free_found_r <= 1'b1;
      end
      if (rd_act_r && (!best_vld_r || rd_id_r < best_id_r)) begin
        best_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (!rd_act_r && !free_found_r) begin
        free_idx_r <= rd_idx_r;
      end
      if (rd_act_r && (!best_vld_r || rd_id_r < best_id_r)) begin
        best_idx_r <= rd_idx_r;
        best_id_r  <= rd_id_r;
      end
    end
  end

  // id counter wraps past zero back to one
  always_comb begin
    next_id_inc = next_id_r + IdW'(1);
    if (next_id_inc == '0) begin
      next_id_inc = IdW'(1);
    end
  end

  always_comb begin
    active_nxt  = active_r;
    next_id_nxt = next_id_r;
    live_nxt    = live_r;
    mem_we      = 1'b0;
    wr_slot     = '0;
    res_nxt     = '0;
    case (cmd_r)
      CmdAlloc: begin
        if (free_found_r) begin
          wr_slot  = free_idx_r;
          mem_we   = 1'b1;
          live_nxt = live_r + CntW'(1);
        end else if (replace_r && best_vld_r) begin
          // evict and refill the same slot, count unchanged
          wr_slot            = best_idx_r;
          mem_we             = 1'b1;
          res_nxt.evicted    = 1'b1;
          res_nxt.evicted_id = best_id_r;
        end
        if (mem_we) begin
          active_nxt[wr_slot]  = 1'b1;
          next_id_nxt          = next_id_inc;
          res_nxt.success      = 1'b1;
          res_nxt.granted_slot = wr_slot;
          res_nxt.granted_id   = next_id_r;
        end
      end
      CmdRelease: begin
        if (CntW'(slot_r) < CntW'(MaxSlots)) begin
          res_nxt.success = 1'b1;
          if (active_r[slot_r]) begin
            active_nxt[slot_r] = 1'b0;
            live_nxt           = live_r - CntW'(1);
          end
        end
      end
      CmdClear: begin
        active_nxt      = '0;
        live_nxt        = '0;
        next_id_nxt     = IdW'(1);
        res_nxt.success = 1'b1;
      end
      default: ;
    endcase
    res_nxt.active_count = live_nxt;
    if (!cmd.commit) begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      next_id_r <= IdW'(1);
      live_r    <= '0;
    end else if (cmd.commit) begin
      active_r  <= active_nxt;
      next_id_r <= next_id_nxt;
      live_r    <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_r <= res_nxt;
    end
  end

  assign result = result_r;

endmodule

// ===== design/slot_allocator_replace_oldest.sv =====
// channel   dir  handshake      beat
// in_ch     in   valid/ready    command, slot
// out_ch    out  valid/ready    success, granted_slot, granted_id, evicted, evicted_id,
//                               active_count
// cfg_ch    in   valid/ready    index, data (0 capacity, 1 replace_oldest)
//
// allocate scans slots 0 to capacity-1, then drains the last read and commits:
// the scan reads one slot id per cycle from the single-read-port id store.
// release, clear and unused codes skip the scan and go straight to commit.
// reset frees every slot, sets the next id to one and capacity to 64; no clearing pass.
// a new command is taken while the previous result waits on out_ch.ready;
// its result then holds until that beat is taken. cfg_ch is always ready.
module slot_allocator_replace_oldest (
  input logic             clk,
  input logic             rst_n,
  slotalloc_in_if.sink    in_ch,
  slotalloc_out_if.source out_ch,
  slotalloc_cfg_if.sink   cfg_ch
);
  import slotalloc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  res_t       result;
  logic       cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

  slotalloc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd),
    .status     (status)
  );

  slotalloc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_command (in_ch.command),
    .in_slot    (in_ch.slot),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .result     (result)
  );

  assign out_ch.success      = result.success;
  assign out_ch.granted_slot = result.granted_slot;
  assign out_ch.granted_id   = result.granted_id;
  assign out_ch.evicted      = result.evicted;
  assign out_ch.evicted_id   = result.evicted_id;
  assign out_ch.active_count = result.active_count;

endmodule
